>>> sv/circle_pair_impulse_collision_unit_assert.svh
// assertion macros for the circle pair impulse collision unit
`ifndef CIRCLE_PAIR_IMPULSE_COLLISION_UNIT_ASSERT_SVH
`define CIRCLE_PAIR_IMPULSE_COLLISION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, skipped while reset is asserted
`define CPIC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cpic assertion failed");
// checked property, also during reset
`define CPIC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cpic assertion failed");
`else
`define CPIC_ASSERT(lbl, clk, rst_n, prop)
`define CPIC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> sv/cpic_pkg.sv
// shared types and constants of the circle pair impulse collision unit
package cpic_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    OUTCOME_NONE       = 2'd0,
    OUTCOME_SEPARATING = 2'd1,
    OUTCOME_RESOLVED   = 2'd2
  } outcome_e;

  // classified pair as it travels from the front part to the back part
  typedef struct packed {
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic [30:0]        r1;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic [30:0]        r2;
    logic               dx_neg;
    logic               dy_neg;
    logic [31:0]        adx;
    logic [31:0]        ady;
    logic [31:0]        rs;
    logic signed [32:0] dvx;
    logic signed [32:0] dvy;
    logic [63:0]        d2;
    logic               overlap;
  } item_t;

endpackage

>>> sv/cpic_in_if.sv
// input channel: one candidate circle pair per transaction
interface cpic_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_pos_x;
  logic signed [31:0] first_pos_y;
  logic signed [31:0] first_vel_x;
  logic signed [31:0] first_vel_y;
  logic [30:0]        first_radius;
  logic signed [31:0] second_pos_x;
  logic signed [31:0] second_pos_y;
  logic signed [31:0] second_vel_x;
  logic signed [31:0] second_vel_y;
  logic [30:0]        second_radius;

  modport source (
    output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius,
    output second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_radius,
    input  ready
  );
  modport sink (
    input  valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius,
    input  second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_radius,
    output ready
  );
endinterface

>>> sv/cpic_out_if.sv
// output channel: one updated circle pair per transaction
interface cpic_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_first_pos_x;
  logic signed [31:0] new_first_pos_y;
  logic signed [31:0] new_first_vel_x;
  logic signed [31:0] new_first_vel_y;
  logic signed [31:0] new_second_pos_x;
  logic signed [31:0] new_second_pos_y;
  logic signed [31:0] new_second_vel_x;
  logic signed [31:0] new_second_vel_y;
  logic [1:0]         outcome;

  modport source (
    output valid, new_first_pos_x, new_first_pos_y, new_first_vel_x, new_first_vel_y,
    output new_second_pos_x, new_second_pos_y, new_second_vel_x, new_second_vel_y,
    output outcome,
    input  ready
  );
  modport sink (
    input  valid, new_first_pos_x, new_first_pos_y, new_first_vel_x, new_first_vel_y,
    input  new_second_pos_x, new_second_pos_y, new_second_vel_x, new_second_vel_y,
    input  outcome,
    output ready
  );
endinterface

>>> sv/circle_pair_impulse_collision_unit.sv
// top level of the circle pair impulse collision unit
// usage:
//   in_i carries one candidate pair per transaction: two circles with
//   position and velocity in signed q16.16 and radius in unsigned q15.16;
//   out_o returns the updated pair and an outcome code (no overlap,
//   separating, resolved)
//   pipeline: 3 front stages, the queue register and 70 back stages
//   throughput: one pair per cycle while out_o is ready; the back part
//   spends one stage per digit in the 32 step square root and in the two
//   31 step normal dividers, the mass ratio dividers run alongside the root
//   reset: all valid bits and queue pointers clear at once, no pairs in
//   flight afterwards, no clearing pass
//   stall: with a result waiting and out_o not ready the back part holds;
//   the queue then fills, after which the front part holds and in_i.ready drops
//   results come out in the order the pairs went in
module circle_pair_impulse_collision_unit #(
  parameter int unsigned QUEUE_DEPTH = cpic_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpic_in_if.sink    in_i,
  cpic_out_if.source out_o
);

  // front to queue
  cpic_pkg::item_t fr_item;
  logic            fr_valid;
  logic            fr_ready;

  // queue to back
  cpic_pkg::item_t bk_item;
  logic            bk_valid;
  logic            bk_ready;

  // differences, squares and the overlap test
  cpic_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .item_o  (fr_item),
    .valid_o (fr_valid),
    .ready_i (fr_ready)
  );

  // decouples the classifier from the long arithmetic pipeline
  cpic_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (fr_item),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .item_o  (bk_item),
    .valid_o (bk_valid),
    .ready_i (bk_ready)
  );

  // root, normals, impulse, positional correction, saturation
  cpic_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (bk_item),
    .valid_i (bk_valid),
    .ready_o (bk_ready),
    .out_o   (out_o)
  );

endmodule

>>> sv/cpic_front.sv
// front part: takes pairs, forms differences and squares, classifies overlap
module cpic_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  cpic_in_if.sink        in_i,
  output cpic_pkg::item_t item_o,
  output logic           valid_o,
  input  logic           ready_i
);

  cpic_pkg::item_t s1_d, s1_q, s2_q, s3_d, s3_q;
  logic s1_vld_q, s2_vld_q, s3_vld_q;
  logic [63:0] dx2_d, dx2_q, dy2_d, dy2_q, rs2_d, rs2_q;
  logic en;

  assign en = !s3_vld_q || ready_i;
  assign in_i.ready = en;

  always_comb begin
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    s1_d     = '0;
    s1_d.p1x = in_i.first_pos_x;
    s1_d.p1y = in_i.first_pos_y;
    s1_d.v1x = in_i.first_vel_x;
    s1_d.v1y = in_i.first_vel_y;
    s1_d.r1  = in_i.first_radius;
    s1_d.p2x = in_i.second_pos_x;
    s1_d.p2y = in_i.second_pos_y;
    s1_d.v2x = in_i.second_vel_x;
    s1_d.v2y = in_i.second_vel_y;
    s1_d.r2  = in_i.second_radius;
    dx = {in_i.first_pos_x[31], in_i.first_pos_x} - {in_i.second_pos_x[31], in_i.second_pos_x};
    dy = {in_i.first_pos_y[31], in_i.first_pos_y} - {in_i.second_pos_y[31], in_i.second_pos_y};
    s1_d.dx_neg = dx[32];
    s1_d.dy_neg = dy[32];
    s1_d.adx = dx[32] ? 32'(-dx) : dx[31:0];
    s1_d.ady = dy[32] ? 32'(-dy) : dy[31:0];
    s1_d.rs  = {1'b0, in_i.first_radius} + {1'b0, in_i.second_radius};
    s1_d.dvx = {in_i.first_vel_x[31], in_i.first_vel_x}
             - {in_i.second_vel_x[31], in_i.second_vel_x};
    s1_d.dvy = {in_i.first_vel_y[31], in_i.first_vel_y}
             - {in_i.second_vel_y[31], in_i.second_vel_y};
  end

  assign dx2_d = 64'(s1_q.adx) * 64'(s1_q.adx);
  assign dy2_d = 64'(s1_q.ady) * 64'(s1_q.ady);
  assign rs2_d = 64'(s1_q.rs) * 64'(s1_q.rs);

  always_comb begin
    logic [64:0] sum;
    sum = {1'b0, dx2_q} + {1'b0, dy2_q};
    s3_d = s2_q;
    s3_d.d2 = sum[63:0];
    s3_d.overlap = sum < {1'b0, rs2_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      s2_q  <= s1_q;
      dx2_q <= dx2_d;
      dy2_q <= dy2_d;
      rs2_q <= rs2_d;
      s3_q  <= s3_d;
    end
  end

  assign item_o  = s3_q;
  assign valid_o = s3_vld_q;

endmodule

>>> sv/cpic_queue.sv
// short queue between the front part and the back part
`include "circle_pair_impulse_collision_unit_assert.svh"
module cpic_queue #(
  parameter int unsigned DEPTH = cpic_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cpic_pkg::item_t item_i,
  input  logic            valid_i,
  output logic            ready_o,
  output cpic_pkg::item_t item_o,
  output logic            valid_o,
  input  logic            ready_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cpic_pkg::item_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CW-1:0] count_d, count_q;
  logic push, pop;

  assign ready_o = count_q != CW'(DEPTH);
  assign valid_o = count_q != '0;
  assign push    = valid_i && ready_o;
  assign pop     = ready_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `CPIC_ASSERT_ALWAYS(a_count_bound, clk_i, !rst_ni || (count_q <= CW'(DEPTH)))
  `CPIC_ASSERT(a_fill_step, clk_i, rst_ni, (push && !pop) |=> count_q == $past(count_q) + 1'b1)
  `CPIC_ASSERT(a_drain_step, clk_i, rst_ni, (pop && !push) |=> count_q == $past(count_q) - 1'b1)

endmodule

>>> sv/cpic_back.sv
// back part: square root, normals, impulse and correction, saturation
module cpic_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cpic_pkg::item_t item_i,
  input  logic            valid_i,
  output logic            ready_o,
  cpic_out_if.source      out_o
);

  localparam int unsigned NSTG     = 70;
  localparam int unsigned SQ_LAST  = 31;
  localparam int unsigned F_LAST   = 30;
  localparam int unsigned N_FIRST  = 32;
  localparam int unsigned N_LAST   = 62;
  localparam int unsigned NORM_STG = 63;
  localparam int unsigned DOT_STG  = 64;
  localparam int unsigned SUM_STG  = 65;
  localparam int unsigned Q_STG    = 66;
  localparam int unsigned GC_STG   = 67;
  localparam int unsigned AL_STG   = 68;
  localparam int unsigned OUT_STG  = 69;

  typedef struct packed {
    logic [31:0] rem;
    logic [30:0] quo;
  } div_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] res;
  } sq_t;

  typedef struct packed {
    cpic_pkg::item_t    it;
    sq_t                sq;
    div_t               f1;
    div_t               f2;
    div_t               ndx;
    div_t               ndy;
    logic [30:0]        nmx;
    logic [30:0]        nmy;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [64:0] sx;
    logic signed [64:0] sy;
    logic signed [65:0] s;
    logic               sep;
    logic [34:0]        q;
    logic [31:0]        pen;
    logic [34:0]        g1;
    logic [34:0]        g2;
    logic [34:0]        c1;
    logic [34:0]        c2;
    logic [7:0][34:0]   al;
    logic [7:0][31:0]   res;
    cpic_pkg::outcome_e outcome;
  } bk_t;

  // integer quotient bit of num / den, num <= den
  function automatic div_t div_init(input logic [31:0] num, input logic [31:0] den);
    div_t r;
    logic top;
    top   = num >= den;
    r.rem = top ? num - den : num;
    r.quo = {30'd0, top};
    return r;
  endfunction

  // one restoring division step
  function automatic div_t div_step(input div_t x, input logic [31:0] den);
    div_t r;
    logic [32:0] t;
    logic b;
    t     = {x.rem, 1'b0};
    b     = t >= {1'b0, den};
    r.rem = b ? 32'(t - {1'b0, den}) : t[31:0];
    r.quo = {x.quo[29:0], b};
    return r;
  endfunction

  // one digit of the bitwise integer square root
  function automatic sq_t sqrt_step(input sq_t x, input logic [63:0] bitv);
    sq_t r;
    logic [63:0] trial;
    trial = x.res + bitv;
    if (x.v >= trial) begin
      r.v   = x.v - trial;
      r.res = (x.res >> 1) + bitv;
    end else begin
      r.v   = x.v;
      r.res = x.res >> 1;
    end
    return r;
  endfunction

  // add or subtract a magnitude and saturate to 32 bit signed
  function automatic logic [31:0] sat_add(input logic [31:0] p, input logic [34:0] a,
                                          input logic sub);
    logic [36:0] e;
    logic [36:0] r;
    e = {{5{p[31]}}, p};
    r = sub ? e - {2'b00, a} : e + {2'b00, a};
    if (!r[36] && (r[35:31] != 5'd0)) begin
      return 32'h7fff_ffff;
    end else if (r[36] && (r[35:31] != 5'h1f)) begin
      return 32'h8000_0000;
    end
    return r[31:0];
  endfunction

  bk_t st_q [NSTG];
  bk_t nxt [NSTG];
  logic [NSTG-1:0] vld_q;
  logic en;

  assign en      = !vld_q[OUT_STG] || out_o.ready;
  assign ready_o = en;

  always_comb begin
    bk_t head;
    bk_t cur;
    logic [63:0] bitv;
    logic [31:0] dd;
    logic dz;
    logic [65:0] ms;
    logic [67:0] t3;
    logic [65:0] prod;
    logic [34:0] m;
    logic [30:0] nm;
    logic [7:0][31:0] base;
    logic neg;
    head    = '0;
    head.it = item_i;
    for (int i = 0; i < NSTG; i++) begin
      cur = (i == 0) ? head : st_q[(i == 0) ? 0 : i - 1];
      if (i <= SQ_LAST) begin
        if (i == 0) begin
          cur.sq.v   = cur.it.d2;
          cur.sq.res = '0;
        end
        bitv   = 64'd1 << (62 - 2 * i);
        cur.sq = sqrt_step(cur.sq, bitv);
      end
      if (i == 0) begin
        cur.f1 = div_init({1'b0, cur.it.r1}, cur.it.rs);
        cur.f2 = div_init({1'b0, cur.it.r2}, cur.it.rs);
      end else if (i <= F_LAST) begin
        cur.f1 = div_step(cur.f1, cur.it.rs);
        cur.f2 = div_step(cur.f2, cur.it.rs);
      end
      dd = cur.sq.res[31:0];
      if (i == N_FIRST) begin
        cur.ndx = div_init(cur.it.adx, dd);
        cur.ndy = div_init(cur.it.ady, dd);
      end else if ((i > N_FIRST) && (i <= N_LAST)) begin
        cur.ndx = div_step(cur.ndx, dd);
        cur.ndy = div_step(cur.ndy, dd);
      end
      if (i == NORM_STG) begin
        // coincident centers give a zero normal
        dz = dd == '0;
        cur.nmx = dz ? '0 : cur.ndx.quo;
        cur.nmy = dz ? '0 : cur.ndy.quo;
        cur.nx = cur.it.dx_neg ? -$signed({1'b0, cur.nmx}) : $signed({1'b0, cur.nmx});
        cur.ny = cur.it.dy_neg ? -$signed({1'b0, cur.nmy}) : $signed({1'b0, cur.nmy});
      end
      if (i == DOT_STG) begin
        cur.sx = $signed({{32{cur.it.dvx[32]}}, cur.it.dvx})
               * $signed({{33{cur.nx[31]}}, cur.nx});
        cur.sy = $signed({{32{cur.it.dvy[32]}}, cur.it.dvy})
               * $signed({{33{cur.ny[31]}}, cur.ny});
      end
      if (i == SUM_STG) begin
        cur.s   = {cur.sx[64], cur.sx} + {cur.sy[64], cur.sy};
        cur.sep = !cur.s[65] && (cur.s != '0);
      end
      if (i == Q_STG) begin
        ms    = 66'd0 - cur.s;
        t3    = {2'b00, ms} + {1'b0, ms, 1'b0};
        cur.q   = t3[65:31];
        cur.pen = cur.it.rs - dd;
      end
      if (i == GC_STG) begin
        prod   = 66'(cur.q) * 66'(cur.f1.quo);
        cur.g1 = prod[64:30];
        prod   = 66'(cur.q) * 66'(cur.f2.quo);
        cur.g2 = prod[64:30];
        prod   = 66'(cur.pen) * 66'(cur.f1.quo);
        cur.c1 = prod[64:30];
        prod   = 66'(cur.pen) * 66'(cur.f2.quo);
        cur.c2 = prod[64:30];
      end
      if (i == AL_STG) begin
        for (int k = 0; k < 8; k++) begin
          case (k / 2)
            0:       m = cur.c2;
            1:       m = cur.g2;
            2:       m = cur.c1;
            default: m = cur.g1;
          endcase
          nm = (k % 2 == 0) ? cur.nmx : cur.nmy;
          prod = 66'(m) * 66'(nm);
          cur.al[k] = prod[64:30];
        end
      end
      if (i == OUT_STG) begin
        base = {cur.it.v2y, cur.it.v2x, cur.it.p2y, cur.it.p2x,
                cur.it.v1y, cur.it.v1x, cur.it.p1y, cur.it.p1x};
        if (!cur.it.overlap) begin
          cur.outcome = cpic_pkg::OUTCOME_NONE;
          cur.res     = base;
        end else if (cur.sep) begin
          cur.outcome = cpic_pkg::OUTCOME_SEPARATING;
          cur.res     = base;
        end else begin
          cur.outcome = cpic_pkg::OUTCOME_RESOLVED;
          for (int k = 0; k < 8; k++) begin
            neg = (k % 2 == 0) ? cur.it.dx_neg : cur.it.dy_neg;
            cur.res[k] = sat_add(base[k], cur.al[k], neg ^ (k >= 4));
          end
        end
      end
      nxt[i] = cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NSTG; i++) begin
        st_q[i] <= nxt[i];
      end
    end
  end

  assign out_o.valid            = vld_q[OUT_STG];
  assign out_o.new_first_pos_x  = st_q[OUT_STG].res[0];
  assign out_o.new_first_pos_y  = st_q[OUT_STG].res[1];
  assign out_o.new_first_vel_x  = st_q[OUT_STG].res[2];
  assign out_o.new_first_vel_y  = st_q[OUT_STG].res[3];
  assign out_o.new_second_pos_x = st_q[OUT_STG].res[4];
  assign out_o.new_second_pos_y = st_q[OUT_STG].res[5];
  assign out_o.new_second_vel_x = st_q[OUT_STG].res[6];
  assign out_o.new_second_vel_y = st_q[OUT_STG].res[7];
  assign out_o.outcome          = 2'(st_q[OUT_STG].outcome);

endmodule

>>> tb/sv/circle_pair_impulse_collision_unit_tb.sv
// self-checking testbench of the circle pair impulse collision unit
module circle_pair_impulse_collision_unit_tb;

  // one candidate pair as driven on the input channel
  typedef struct {
    logic signed [31:0] p1x, p1y, v1x, v1y;
    logic [30:0]        r1;
    logic signed [31:0] p2x, p2y, v2x, v2y;
    logic [30:0]        r2;
  } pair_t;

  // one updated pair as seen on the output channel
  typedef struct packed {
    logic signed [31:0] p1x, p1y, v1x, v1y;
    logic signed [31:0] p2x, p2y, v2x, v2y;
    cpic_pkg::outcome_e outcome;
  } update_t;

  localparam int NORM = 30;  // fraction bits of the unit normal
  localparam int LATENCY = 74;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cpic_in_if  in_ch ();
  cpic_out_if out_ch ();

  circle_pair_impulse_collision_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #1 clk_i = ~clk_i;

  update_t pending_updates[$];   // predicted updates in transaction order
  int      mismatches = 0;
  bit      idle_on = 1'b1;       // random idling on both channels
  int      hold_cycles = 0;      // long receiver hold-off request

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // integer square root, rounded down
  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_w;
    res = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // signed normal component times unsigned magnitude, truncated toward zero
  function automatic logic signed [127:0] scale_along(logic signed [127:0] n,
                                                       logic [127:0] m);
    logic [127:0] t;
    t = (m * (n < 0 ? 128'(-n) : 128'(n))) >> NORM;
    return n < 0 ? -$signed(t) : $signed(t);
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic update_t resolve_pair(pair_t p);
    logic signed [127:0] dx, dy, nx, ny, dvx, dvy, closing;
    logic [127:0]        adx, ady, rs, dist2, dlen, q, f1, f2, g1, g2, pen, c1, c2;
    update_t u;
    u.p1x = p.p1x; u.p1y = p.p1y; u.v1x = p.v1x; u.v1y = p.v1y;
    u.p2x = p.p2x; u.p2y = p.p2y; u.v2x = p.v2x; u.v2y = p.v2y;
    u.outcome = cpic_pkg::OUTCOME_NONE;
    dx = 128'(p.p1x) - 128'(p.p2x);
    dy = 128'(p.p1y) - 128'(p.p2y);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    rs = 128'(p.r1) + 128'(p.r2);
    if (adx < rs && ady < rs) begin
      dist2 = adx * adx + ady * ady;
      if (dist2 < rs * rs) begin
        dlen = 128'(root_floor(dist2[63:0]));
        nx = 0;
        ny = 0;
        if (dlen != 0) begin
          nx = $signed((adx << NORM) / dlen);
          ny = $signed((ady << NORM) / dlen);
          if (dx < 0) nx = -nx;
          if (dy < 0) ny = -ny;
        end
        dvx = 128'(p.v1x) - 128'(p.v2x);
        dvy = 128'(p.v1y) - 128'(p.v2y);
        closing = dvx * nx + dvy * ny;
        if (closing > 0) begin
          u.outcome = cpic_pkg::OUTCOME_SEPARATING;
        end else begin
          // 1.5 times the closing speed: restitution 0.5 plus one
          q = (128'(-closing) * 3) >> 31;
          f1 = (128'(p.r1) << NORM) / rs;
          f2 = (128'(p.r2) << NORM) / rs;
          g1 = (q * f1) >> NORM;
          g2 = (q * f2) >> NORM;
          pen = rs - dlen;
          c1 = (pen * f1) >> NORM;
          c2 = (pen * f2) >> NORM;
          u.outcome = cpic_pkg::OUTCOME_RESOLVED;
          u.p1x = clamp32(128'(p.p1x) + scale_along(nx, c2));
          u.p1y = clamp32(128'(p.p1y) + scale_along(ny, c2));
          u.v1x = clamp32(128'(p.v1x) + scale_along(nx, g2));
          u.v1y = clamp32(128'(p.v1y) + scale_along(ny, g2));
          u.p2x = clamp32(128'(p.p2x) - scale_along(nx, c1));
          u.p2y = clamp32(128'(p.p2y) - scale_along(ny, c1));
          u.v2x = clamp32(128'(p.v2x) - scale_along(nx, g1));
          u.v2y = clamp32(128'(p.v2y) - scale_along(ny, g1));
        end
      end
    end
    return u;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // random signed value of random magnitude, so every bit toggles
  function automatic logic signed [31:0] rand_scaled();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  function automatic logic [30:0] rand_radius();
    logic [30:0] r;
    r = 31'($urandom) >> $urandom_range(0, 30);
    return r == 0 ? 31'd1 : r;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    longint reach;
    int kind;
    kind = $urandom_range(0, 9);
    p.r1 = rand_radius();
    p.r2 = rand_radius();
    p.v1x = rand_scaled(); p.v1y = rand_scaled();
    p.v2x = rand_scaled(); p.v2y = rand_scaled();
    p.p2x = rand_scaled(); p.p2y = rand_scaled();
    reach = longint'(p.r1) + longint'(p.r2);
    if (kind <= 6) begin
      // mostly overlapping: offset inside the radius sum
      p.p1x = clip32(longint'(p.p2x) + $signed(64'($urandom)) % reach);
      p.p1y = clip32(longint'(p.p2y) + $signed(64'($urandom)) % reach);
    end else if (kind == 7) begin
      // coincident centers
      p.p1x = p.p2x;
      p.p1y = p.p2y;
    end else if (kind == 8) begin
      // just outside contact along one axis
      p.p1x = clip32(longint'(p.p2x) + reach + $urandom_range(0, 3));
      p.p1y = p.p2y;
    end else begin
      p.p1x = $signed($urandom);
      p.p1y = $signed($urandom);
      p.r1 = 31'($urandom);
      p.r2 = 31'($urandom);
    end
    return p;
  endfunction

  function automatic pair_t make_pair(int p1x, int p1y, int v1x, int v1y, int r1,
                                      int p2x, int p2y, int v2x, int v2y, int r2);
    pair_t p;
    p.p1x = p1x; p.p1y = p1y; p.v1x = v1x; p.v1y = v1y; p.r1 = 31'(r1);
    p.p2x = p2x; p.p2y = p2y; p.v2x = v2x; p.v2y = v2y; p.r2 = 31'(r2);
    return p;
  endfunction

  // ---------------------------------------------------------------------
  // input driver: one transaction per call, called at a falling edge
  // ---------------------------------------------------------------------
  task automatic send_pair(pair_t p);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.first_pos_x   <= p.p1x;
    in_ch.first_pos_y   <= p.p1y;
    in_ch.first_vel_x   <= p.v1x;
    in_ch.first_vel_y   <= p.v1y;
    in_ch.first_radius  <= p.r1;
    in_ch.second_pos_x  <= p.p2x;
    in_ch.second_pos_y  <= p.p2y;
    in_ch.second_vel_x  <= p.v2x;
    in_ch.second_vel_y  <= p.v2y;
    in_ch.second_radius <= p.r2;
    // wait for the accepting edge
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_updates = {pending_updates, resolve_pair(p)};
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
  endtask

  // wait until every predicted update came back, then some slack
  task automatic drain();
    stop_sending();
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // output side: ready pattern and checker
  // ---------------------------------------------------------------------
  initial begin
    @(negedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        // long hold-off so the pipeline fills and in_i.ready drops
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    update_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.p1x = out_ch.new_first_pos_x;
      got.p1y = out_ch.new_first_pos_y;
      got.v1x = out_ch.new_first_vel_x;
      got.v1y = out_ch.new_first_vel_y;
      got.p2x = out_ch.new_second_pos_x;
      got.p2y = out_ch.new_second_pos_y;
      got.v2x = out_ch.new_second_vel_x;
      got.v2y = out_ch.new_second_vel_y;
      got.outcome = cpic_pkg::outcome_e'(out_ch.outcome);
      if (pending_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        want = pending_updates.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch");
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  localparam int Q1 = 65536;  // 1.0 in q16.16
  localparam int MAXI = 32'h7fffffff;
  localparam int MINI = 32'h80000000;

  task automatic test_directed();
    // far apart, no overlap
    send_pair(make_pair(0, 0, Q1, 0, Q1, 10 * Q1, 0, -Q1, 0, Q1));
    // head-on approach along x
    send_pair(make_pair(0, 0, Q1, 0, Q1, Q1, 0, -Q1, 0, Q1));
    // overlapping but moving apart
    send_pair(make_pair(0, 0, -Q1, 0, Q1, Q1, 0, Q1, 0, Q1));
    // diagonal contact, unequal masses
    send_pair(make_pair(0, 0, 3 * Q1, 2 * Q1, 2 * Q1, Q1, Q1, -Q1, 0, Q1 / 2));
    // coincident centers
    send_pair(make_pair(5 * Q1, -7 * Q1, Q1, Q1, Q1, 5 * Q1, -7 * Q1, 0, 0, Q1));
    // zero radius on one side takes the whole impulse
    send_pair(make_pair(0, 0, Q1, 0, 0, Q1 / 2, 0, -Q1, 0, Q1));
    // both radii zero never overlap
    send_pair(make_pair(0, 0, Q1, 0, 0, 0, 0, -Q1, 0, 0));
    // largest radii, extreme corners and velocities: saturation
    send_pair(make_pair(MAXI, MAXI, MAXI, MAXI, MAXI, MINI, MINI, MINI, MINI, MAXI));
    send_pair(make_pair(MINI, MINI, MINI, MAXI, MAXI, MAXI, MAXI, MAXI, MINI, MAXI));
    send_pair(make_pair(MAXI, 0, MAXI, 0, MAXI, MAXI - 1, 0, MINI, 0, 1));
    send_pair(make_pair(MINI, 0, MINI, MINI, 1, MINI + 1, 0, MAXI, MAXI, MAXI));
    // touching exactly: equal to the radius sum, no overlap; then one unit closer
    send_pair(make_pair(0, 0, Q1, 0, Q1, 2 * Q1, 0, -Q1, 0, Q1));
    send_pair(make_pair(0, 0, Q1, 0, Q1, 2 * Q1 - 1, 0, -Q1, 0, Q1));
    // smallest radii, one unit apart
    send_pair(make_pair(0, 0, 1, 1, 1, 1, 0, -1, -1, 1));
    // zero relative velocity still corrects positions
    send_pair(make_pair(0, 0, 7, 7, Q1, 0, Q1 / 4, 7, 7, Q1));
    // all ones and all zeros patterns
    send_pair(make_pair(-1, -1, -1, -1, MAXI, 0, 0, 0, 0, MAXI));
    drain();  // sender pauses until every result is back
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_cycles = 300;
    repeat (150) send_pair(rand_pair());
    drain();
    idle_on = 1'b1;
  endtask

  task automatic test_random_bursty();
    repeat (500) send_pair(rand_pair());
  endtask

  task automatic test_random_streaming();
    idle_on = 1'b0;
    repeat (150) send_pair(rand_pair());
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    in_ch.valid = 1'b0;
    in_ch.first_pos_x = '0;  in_ch.first_pos_y = '0;
    in_ch.first_vel_x = '0;  in_ch.first_vel_y = '0;
    in_ch.first_radius = '0;
    in_ch.second_pos_x = '0; in_ch.second_pos_y = '0;
    in_ch.second_vel_x = '0; in_ch.second_vel_y = '0;
    in_ch.second_radius = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_backpressure();
    test_random_bursty();
    test_random_streaming();
    drain();

    if (mismatches == 0 && pending_updates.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> circle_pair_impulse_collision_unit.f
+incdir+sv
sv/cpic_pkg.sv
sv/cpic_in_if.sv
sv/cpic_out_if.sv
sv/cpic_front.sv
sv/cpic_queue.sv
sv/cpic_back.sv
sv/circle_pair_impulse_collision_unit.sv
tb/sv/circle_pair_impulse_collision_unit_tb.sv
